>>> hw/rtl/sspr_pkg.sv
// Shared types and codes for the servo status packet receiver.
// Used by sspr_front, sspr_queue, sspr_back and the top level; depends on nothing.
package sspr_pkg;

    localparam int CNT_W = 7;
    localparam int IDX_W = 6;
    localparam logic [7:0] HDR_BYTE = 8'hFF;
    localparam logic [7:0] MIN_LEN  = 8'd2;

    typedef enum logic [2:0] {
        PH_HUNT0  = 3'd0,
        PH_HUNT1  = 3'd1,
        PH_ID     = 3'd2,
        PH_LEN    = 3'd3,
        PH_STATUS = 3'd4,
        PH_PARAM  = 3'd5,
        PH_CHECK  = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        OC_PARAM     = 3'd0,
        OC_GOOD_NONE = 3'd1,
        OC_WRONG_ID  = 3'd2,
        OC_SHORT     = 3'd3,
        OC_TOO_LONG  = 3'd4,
        OC_CKSUM     = 3'd5,
        OC_SERVO     = 3'd6
    } outcome_t;

    typedef enum logic {
        BK_IDLE  = 1'b0,
        BK_DRAIN = 1'b1
    } bk_state_t;

    typedef struct packed {
        outcome_t           oc;
        logic [7:0]         status;
        logic [CNT_W-1:0]   count;
    } job_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [7:0]         data;
    } wr_port_t;

endpackage

>>> hw/rtl/sspr_front.sv
// Front end: header hunt, field checks and checksum; writes parameter bytes
// and posts one job per finished packet. Depends on sspr_pkg.
module sspr_front #(
    parameter int MAX_PARAMS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        match_id,
    input  logic              q_full,
    input  logic              back_busy,
    output logic              push,
    output sspr_pkg::job_t    push_job,
    output sspr_pkg::wr_port_t wr
);
    import sspr_pkg::*;

    localparam logic [8:0] LEN_MAX = 9'(MAX_PARAMS + 2);

    phase_t             phase_reg, phase_next;
    logic [7:0]         seen_id_reg, seen_id_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic [7:0]         sum_reg, sum_next;
    logic [7:0]         status_reg, status_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               acc;

    assign in_ready = !q_full && !(phase_reg == PH_PARAM && back_busy);
    assign acc      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT0;
            seen_id_reg <= '0;
            left_reg    <= '0;
            sum_reg     <= '0;
            status_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            seen_id_reg <= seen_id_next;
            left_reg    <= left_next;
            sum_reg     <= sum_next;
            status_reg  <= status_next;
            count_reg   <= count_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        seen_id_next = seen_id_reg;
        left_next    = left_reg;
        sum_next     = sum_reg;
        status_next  = status_reg;
        count_next   = count_reg;
        push         = 1'b0;
        push_job     = '{oc: OC_GOOD_NONE, status: 8'h00, count: '0};
        wr.en        = 1'b0;
        wr.addr      = count_reg[IDX_W-1:0];
        wr.data      = rx_byte;
        if (acc)
        begin
            case (phase_reg)
                PH_HUNT0:
                begin
                    phase_next = (rx_byte == HDR_BYTE) ? PH_HUNT1 : PH_HUNT0;
                end
                PH_HUNT1:
                begin
                    phase_next = (rx_byte == HDR_BYTE) ? PH_ID : PH_HUNT0;
                end
                PH_ID:
                begin
                    seen_id_next = rx_byte;
                    phase_next   = PH_LEN;
                end
                PH_LEN:
                begin
                    if (seen_id_reg != match_id)
                    begin
                        push        = 1'b1;
                        push_job.oc = OC_WRONG_ID;
                        phase_next  = PH_HUNT0;
                    end
                    else if (rx_byte < MIN_LEN)
                    begin
                        push        = 1'b1;
                        push_job.oc = OC_SHORT;
                        phase_next  = PH_HUNT0;
                    end
                    else if ({1'b0, rx_byte} > LEN_MAX)
                    begin
                        push        = 1'b1;
                        push_job.oc = OC_TOO_LONG;
                        phase_next  = PH_HUNT0;
                    end
                    else
                    begin
                        left_next  = CNT_W'(rx_byte - MIN_LEN);
                        sum_next   = seen_id_reg + rx_byte;
                        count_next = '0;
                        phase_next = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    status_next = rx_byte;
                    sum_next    = sum_reg + rx_byte;
                    phase_next  = (left_reg == '0) ? PH_CHECK : PH_PARAM;
                end
                PH_PARAM:
                begin
                    wr.en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + rx_byte;
                    left_next  = left_reg - 1'b1;
                    if (left_reg == CNT_W'(1))
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    push       = 1'b1;
                    phase_next = PH_HUNT0;
                    if (~sum_reg != rx_byte)
                    begin
                        push_job.oc     = OC_CKSUM;
                        push_job.status = status_reg;
                    end
                    else if (status_reg != 8'h00)
                    begin
                        push_job.oc     = OC_SERVO;
                        push_job.status = status_reg;
                    end
                    else if (count_reg == '0)
                    begin
                        push_job.oc = OC_GOOD_NONE;
                    end
                    else
                    begin
                        push_job.oc    = OC_PARAM;
                        push_job.count = count_reg;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT0;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/sspr_queue.sv
// Two-entry job queue between the parser front end and the result back end.
// Depends on sspr_pkg.
module sspr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sspr_pkg::job_t push_job,
    input  logic           pop,
    output sspr_pkg::job_t head,
    output logic           full,
    output logic           empty
);
    import sspr_pkg::*;

    job_t       slot_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign head  = slot_reg[rp_reg];
    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);

    always_comb
    begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("job queue underflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !empty)
        else $error("job queue lost a push");

endmodule

>>> hw/rtl/sspr_back.sv
// Back end: holds the parameter memory, turns jobs into result words and
// drives the output register. Depends on sspr_pkg.
module sspr_back #(
    parameter int MAX_PARAMS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sspr_pkg::wr_port_t wr,
    input  sspr_pkg::job_t     head,
    input  logic               q_empty,
    output logic               pop,
    output logic               busy,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         outcome,
    output logic [7:0]         param_byte,
    output logic [5:0]         param_index,
    output logic [7:0]         servo_status,
    output logic               last
);
    import sspr_pkg::*;

    localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    logic [7:0]        mem [MAX_PARAMS];
    logic [7:0]        rdata_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    bk_state_t         state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              ov_reg, ov_next;
    outcome_t          oc_reg, oc_next;
    logic [7:0]        pb_reg, pb_next;
    logic [IDX_W-1:0]  pi_reg, pi_next;
    logic [7:0]        st_reg, st_next;
    logic              last_reg, last_next;
    logic              slot_free;
    logic              at_end;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    assign slot_free = !ov_reg || out_ready;
    assign at_end    = ({1'b0, idx_reg} + 1'b1) == cnt_reg;
    assign busy      = (state_reg == BK_DRAIN) || !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oc_reg   <= oc_next;
        pb_reg   <= pb_next;
        pi_reg   <= pi_next;
        st_reg   <= st_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !out_ready;
        oc_next    = oc_reg;
        pb_next    = pb_reg;
        pi_next    = pi_reg;
        st_next    = st_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && slot_free)
                begin
                    pop = 1'b1;
                    if (head.oc == OC_PARAM)
                    begin
                        rd_en      = 1'b1;
                        idx_next   = '0;
                        cnt_next   = head.count;
                        state_next = BK_DRAIN;
                    end
                    else
                    begin
                        ov_next   = 1'b1;
                        oc_next   = head.oc;
                        pb_next   = 8'h00;
                        pi_next   = '0;
                        st_next   = head.status;
                        last_next = 1'b1;
                    end
                end
            end
            BK_DRAIN:
            begin
                if (slot_free)
                begin
                    ov_next   = 1'b1;
                    oc_next   = OC_PARAM;
                    pb_next   = rdata_reg;
                    pi_next   = idx_reg;
                    st_next   = 8'h00;
                    last_next = at_end;
                    if (at_end)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign out_valid    = ov_reg;
    assign outcome      = oc_reg;
    assign param_byte   = pb_reg;
    assign param_index  = pi_reg;
    assign servo_status = st_reg;
    assign last         = last_reg;

    a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == BK_IDLE) && q_empty)
        else $error("parameter write while draining");
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DRAIN) |-> ({1'b0, idx_reg} < cnt_reg))
        else $error("drain index past packet end");
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && oc_reg != OC_PARAM) |-> last_reg && pb_reg == 8'h00 && pi_reg == '0)
        else $error("non-parameter result not a single final word");
    a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DRAIN && slot_free && at_end) |=> ov_reg && last_reg)
        else $error("drain finished without a final word");

endmodule

>>> hw/rtl/servo_status_packet_receiver_unit.sv
// Servo status packet receiver: byte stream in, parsed result words out.
// Input channel s_axis_* carries one received byte plus the wanted id per word;
// output channel m_axis_* carries one result word per parameter byte, or one
// word for a good packet without parameters or for any error, tlast on the final
// word of each packet.
// The front end accepts one byte per cycle unless the queue is full or held off
// as below. With the back end idle, a single result word passes from the byte
// that ends its packet through the job queue and the output register, and a
// parameter run also through the memory read register; a good packet with N
// parameters then yields one word per cycle while m_axis_tready stays high, set
// by the single read port of the memory. While a drain is in progress or a job
// is queued, the front end holds off the parameter bytes of the next packet.
// A two-entry job queue lets header bytes of the next packet be taken while
// results wait. If the receiver deasserts m_axis_tready, the output word holds
// and the back end pauses; once the queue fills the input stalls.
// Reset clears the parser to header hunt and empties the queue; the parameter
// memory needs no clearing, since each packet writes before it reads.
// Depends on sspr_pkg, sspr_front, sspr_queue and sspr_back.
module servo_status_packet_receiver_unit #(
    parameter int MAX_PARAMS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] rx_byte, [15:8] match_id
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [2:0] outcome, [10:3] param_byte,
                                       // [16:11] param_index, [24:17] servo_status
    output logic        m_axis_tlast
);
    import sspr_pkg::*;

    logic       q_full, q_empty, push, pop, back_busy;
    job_t       push_job, head;
    wr_port_t   wr;
    logic [2:0] outcome;
    logic [7:0] param_byte;
    logic [5:0] param_index;
    logic [7:0] servo_status;

    sspr_front #(.MAX_PARAMS(MAX_PARAMS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .rx_byte     (s_axis_tdata[7:0]),
        .match_id    (s_axis_tdata[15:8]),
        .q_full      (q_full),
        .back_busy   (back_busy),
        .push        (push),
        .push_job    (push_job),
        .wr          (wr)
    );

    sspr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    sspr_back #(.MAX_PARAMS(MAX_PARAMS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (wr),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .busy         (back_busy),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .outcome      (outcome),
        .param_byte   (param_byte),
        .param_index  (param_index),
        .servo_status (servo_status),
        .last         (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, servo_status, param_index, param_byte, outcome};

endmodule

>>> dv/servo_status_packet_receiver_unit_test.sv
// Self-checking testbench for servo_status_packet_receiver_unit: drives byte words with
// random bursts and gaps, predicts every result word, and checks them under output stalls.
// Depends on sspr_pkg and the servo_status_packet_receiver_unit RTL.
module servo_status_packet_receiver_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sspr_pkg::*;

    localparam int MAX_PARAMS   = 32;
    localparam int BYTE_TARGET  = 460;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        outcome_t   oc;
        logic [7:0] pbyte;
        logic [5:0] pidx;
        logic [7:0] status;
        logic       last;
    } status_result_t;

    class StatusParseScoreboard;
        status_result_t expected_words[$];
        int             errors;
        int             checked;
        int             param_words;
        int             error_words;
        phase_t         phase;
        logic [7:0]     seen_id;
        logic [7:0]     bytes_left;
        logic [7:0]     running_sum;
        logic [7:0]     status_held;
        int             param_count;
        logic [7:0]     param_store [MAX_PARAMS];

        function new();
            errors      = 0;
            checked     = 0;
            param_words = 0;
            error_words = 0;
            phase       = PH_HUNT0;
            seen_id     = 8'd0;
            bytes_left  = 8'd0;
            running_sum = 8'd0;
            status_held = 8'd0;
            param_count = 0;
        endfunction

        function void push_result(outcome_t oc, logic [7:0] pbyte, logic [5:0] pidx,
                                  logic [7:0] status, logic last);
            status_result_t r;
            r.oc     = oc;
            r.pbyte  = pbyte;
            r.pidx   = pidx;
            r.status = status;
            r.last   = last;
            expected_words.push_back(r);
        endfunction

        function void push_error(outcome_t oc, logic [7:0] status);
            push_result(oc, 8'd0, 6'd0, status, 1'b1);
            phase = PH_HUNT0;
        endfunction

        function void note_byte(logic [7:0] b, logic [7:0] want);
            case (phase)
                PH_HUNT0:
                    phase = (b == HDR_BYTE) ? PH_HUNT1 : PH_HUNT0;
                PH_HUNT1:
                    phase = (b == HDR_BYTE) ? PH_ID : PH_HUNT0;
                PH_ID:
                begin
                    seen_id = b;
                    phase   = PH_LEN;
                end
                PH_LEN:
                begin
                    if (seen_id != want)
                        push_error(OC_WRONG_ID, 8'd0);
                    else if (b < MIN_LEN)
                        push_error(OC_SHORT, 8'd0);
                    else if (int'(b - MIN_LEN) > MAX_PARAMS)
                        push_error(OC_TOO_LONG, 8'd0);
                    else
                    begin
                        bytes_left  = b - MIN_LEN;
                        running_sum = seen_id + b;
                        param_count = 0;
                        phase       = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    status_held = b;
                    running_sum = running_sum + b;
                    phase       = (bytes_left == 8'd0) ? PH_CHECK : PH_PARAM;
                end
                PH_PARAM:
                begin
                    if (param_count < MAX_PARAMS)
                        param_store[param_count] = b;
                    param_count++;
                    running_sum = running_sum + b;
                    if (bytes_left > 8'd0)
                        bytes_left--;
                    if (bytes_left == 8'd0)
                        phase = PH_CHECK;
                end
                PH_CHECK:
                begin
                    if (8'(~running_sum) != b)
                        push_error(OC_CKSUM, status_held);
                    else if (status_held != 8'd0)
                        push_error(OC_SERVO, status_held);
                    else
                    begin
                        phase = PH_HUNT0;
                        if (param_count == 0)
                            push_result(OC_GOOD_NONE, 8'd0, 6'd0, 8'd0, 1'b1);
                        else
                        begin
                            if (param_count > MAX_PARAMS)
                                param_count = MAX_PARAMS;
                            for (int i = 0; i < param_count; i++)
                                push_result(OC_PARAM, param_store[i], 6'(i), 8'd0,
                                            (i + 1 == param_count));
                        end
                    end
                end
                default:
                    phase = PH_HUNT0;
            endcase
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_word(logic [31:0] data, logic last);
            status_result_t e;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %08h last %0b",
                         $time, data, last);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            checked++;
            if (e.oc == OC_PARAM)
                param_words++;
            else if (e.oc != OC_GOOD_NONE)
                error_words++;
            compare_field("outcome", int'(e.oc), int'(data[2:0]));
            compare_field("param_byte", int'(e.pbyte), int'(data[10:3]));
            compare_field("param_index", int'(e.pidx), int'(data[16:11]));
            compare_field("servo_status", int'(e.status), int'(data[24:17]));
            compare_field("pad", 0, int'(data[31:25]));
            compare_field("last", int'(e.last), int'(last));
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'd0;  // [7:0] rx_byte, [15:8] match_id
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [2:0] outcome, [10:3] param_byte,
                                         // [16:11] param_index, [24:17] servo_status
    logic        m_axis_tlast;

    StatusParseScoreboard sb = new();

    int  cycle_count = 0;
    int  bytes_sent  = 0;
    int  frames_sent = 0;
    int  burst_left  = 0;
    bit  steady      = 1'b0;

    servo_status_packet_receiver_unit #(
        .MAX_PARAMS(MAX_PARAMS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("servo_status_packet_receiver_unit_test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_byte(s_axis_tdata[7:0], s_axis_tdata[15:8]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tlast);
    end

    // cycle through full-rate, mostly-ready, one-in-four and coin-flip stall modes
    always @(posedge clk)
    begin
        case ((cycle_count / 256) % 4)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= (cycle_count[1:0] == 2'd0);
            default: m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    function automatic logic [7:0] any_id();
        return 8'($urandom_range(0, 253));
    endfunction

    task automatic send_word(input logic [7:0] b, input logic [7:0] want);
        int gap;
        if (burst_left == 0)
        begin
            steady     = ($urandom_range(0, 3) == 0);
            gap        = steady ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {want, b};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // n_body < 0: stop right after the length byte
    task automatic send_packet(input logic [7:0] id, input logic [7:0] want,
                               input logic [7:0] len, input logic [7:0] status,
                               input int n_body, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] pb;
        frames_sent++;
        send_word(HDR_BYTE, any_id());
        send_word(HDR_BYTE, any_id());
        send_word(id, any_id());
        send_word(len, want);
        if (n_body < 0)
            return;
        sum = id + len + status;
        send_word(status, any_id());
        for (int i = 0; i < n_body; i++)
        begin
            pb  = ($urandom_range(0, 15) == 0) ? HDR_BYTE : 8'($urandom_range(0, 255));
            sum = sum + pb;
            send_word(pb, any_id());
        end
        send_word(bad_sum ? ~sum ^ 8'($urandom_range(1, 255)) : ~sum, any_id());
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (sb.expected_words.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] id;
        logic [7:0] want;
        int         r;
        int         n;
        bit         paused;

        paused = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // noise, an interrupted header, then a good packet with no parameters
        send_word(8'h55, any_id());
        send_word(HDR_BYTE, any_id());
        send_word(8'h00, any_id());
        send_packet(8'd1, 8'd1, 8'd2, 8'h00, 0, 1'b0);
        // header byte taken as the id
        send_word(HDR_BYTE, any_id());
        send_packet(HDR_BYTE, 8'd0, 8'd4, 8'h00, -1, 1'b0);
        send_packet(8'd253, 8'd253, 8'd1, 8'h00, -1, 1'b0);
        send_packet(8'd0, 8'd0, 8'd35, 8'h00, -1, 1'b0);
        // bad checksum wins over a nonzero status
        send_packet(8'd9, 8'd9, 8'd3, 8'h20, 1, 1'b1);
        send_packet(8'd2, 8'd2, 8'd2, 8'h01, 0, 1'b0);
        send_packet(8'd3, 8'd3, 8'd3, 8'h00, 1, 1'b0);

        s_axis_tvalid <= 1'b0;
        wait_drained();
        burst_left = 0;

        while (bytes_sent < BYTE_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                id = ($urandom_range(0, 7) == 0) ? 8'd253 : any_id();
                n  = ($urandom_range(0, 19) == 0) ? MAX_PARAMS : $urandom_range(0, 6);
                send_packet(id, id, 8'(n + 2),
                            ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                            n, ($urandom_range(0, 9) == 0));
            end
            else if (r < 65)
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_word(($urandom_range(0, 2) == 0) ? HDR_BYTE
                                                          : 8'($urandom_range(0, 255)),
                              any_id());
            end
            else if (r < 73)
            begin
                id   = 8'($urandom_range(0, 255));
                want = any_id();
                if (want == id)
                    want = 8'((int'(id) + 1) % 254);
                send_packet(id, want, 8'($urandom_range(2, 8)), 8'h00,
                            $urandom_range(0, 1) ? -1 : $urandom_range(0, 4), 1'b0);
            end
            else if (r < 80)
            begin
                id = any_id();
                send_packet(id, id, 8'($urandom_range(0, 1)), 8'h00,
                            $urandom_range(0, 1) ? -1 : $urandom_range(0, 3), 1'b0);
            end
            else if (r < 87)
            begin
                id = any_id();
                send_packet(id, id, ($urandom_range(0, 3) == 0) ? 8'hFF
                                                                : 8'($urandom_range(35, 255)),
                            8'h00, $urandom_range(0, 1) ? -1 : $urandom_range(0, 5), 1'b0);
            end
            else
            begin
                id = any_id();
                n  = $urandom_range(0, 6);
                send_packet(id, id, 8'(n + 2), 8'h00,
                            (n > 0 && $urandom_range(0, 1)) ? $urandom_range(0, n - 1)
                                                            : n + $urandom_range(1, 3),
                            1'b0);
            end

            if (!paused && bytes_sent >= BYTE_TARGET / 2)
            begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                wait_drained();
                burst_left = 0;
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.expected_words.size() != 0)
        begin
            $display("%0t: results left over, expected 0, actual %0d",
                     $time, sb.expected_words.size());
            sb.errors++;
        end

        $display("Run covered %0d bytes in %0d framed packets plus noise, %0d cycles.",
                 bytes_sent, frames_sent, cycle_count);
        $display("Checked %0d result words: %0d parameter bytes, %0d error reports.",
                 sb.checked, sb.param_words, sb.error_words);
        if (sb.errors == 0)
            $display("servo_status_packet_receiver_unit_test passed");
        else
            $display("servo_status_packet_receiver_unit_test failed");
        $finish;
    end

endmodule
